// ----- design/abbp_pkg.sv -----
// Shared constants, types and codes of the aligned bump block pool.
`default_nettype none

package abbp_pkg;

  // Pool geometry and field widths.
  localparam int MAX_BLOCKS = 8;
  localparam int SIZE_BITS  = 32;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int BLK_IDX_W  = 3;
  localparam int OFF_W      = SIZE_BITS + 1;

  // Alignment handling: the log2 saturates at ALIGN_MAX.
  localparam int ALIGN_W    = 4;
  localparam int ALIGN_MAX  = 8;
  localparam int AMASK_W    = ALIGN_MAX + 1;

  // Aligned offset and end-of-grant sums are kept wide enough never to wrap.
  localparam int AL_W       = OFF_W + 1;
  localparam int SUM_W      = AL_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [SIZE_BITS-1:0] RESET_DEFAULT_LENGTH = SIZE_BITS'(65536);
  localparam logic [ALIGN_W-1:0]   RESET_ALIGN_LOG2     = ALIGN_W'(4);

  // Queue between the front and back parts.
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_LEN = 1'b0,
    CFG_ALIGN_LOG2  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CL_ALLOC = 2'd0,
    CL_RESET = 2'd1,
    CL_ZERO  = 2'd2
  } item_class_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_t;

  // One classified command waiting for the back part.
  typedef struct packed {
    item_class_t            cls;
    logic [SIZE_BITS-1:0]   size;
    logic                   minimal;
  } work_item_t;

  // Current configuration register contents.
  typedef struct packed {
    logic [SIZE_BITS-1:0]   default_len;
    logic [ALIGN_W-1:0]     align_log2;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/abbp_front.sv -----
// Front part: accepts commands, classifies them and queues them for the back part.
`default_nettype none

module abbp_front
  import abbp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_command,
  input  wire logic [SIZE_BITS-1:0] in_request_size,
  input  wire logic                 in_minimal,
  output logic                      q_valid,
  output work_item_t                q_item,
  input  wire logic                 q_pop
);

  work_item_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       fill_r, fill_nxt;
  work_item_t              new_item;
  logic                    push;
  logic                    pop;

  // Classify the incoming beat.
  always_comb begin
    new_item.size    = in_request_size;
    new_item.minimal = in_minimal;
    if (in_command) begin
      new_item.cls = CL_RESET;
    end else if (in_request_size == '0) begin
      new_item.cls = CL_ZERO;
    end else begin
      new_item.cls = CL_ALLOC;
    end
  end

  assign busy    = (fill_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = q_mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("queue push without fill increment");
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !pop) |=> busy)
    else $error("queue left full state without a pop");
`endif

endmodule

`default_nettype wire

// ----- design/abbp_back.sv -----
// Back part: first-fit scan over the block pool, offset updates and result beats.
`default_nettype none

module abbp_back
  import abbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic                  q_valid,
  input  wire work_item_t            q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [BLK_IDX_W-1:0]       out_block_index,
  output logic [SIZE_BITS-1:0]       out_grant_offset,
  output logic                       out_new_block,
  output logic [SIZE_BITS-1:0]       out_chosen_length
);

  back_state_t             state_r, state_nxt;
  work_item_t              cur_r, cur_nxt;
  logic [CNT_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SIZE_BITS-1:0]    len_r [MAX_BLOCKS];
  logic [OFF_W-1:0]        off_r [MAX_BLOCKS];

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [BLK_IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [SIZE_BITS-1:0]    out_off_r, out_off_nxt;
  logic                    out_nb_r, out_nb_nxt;
  logic [SIZE_BITS-1:0]    out_len_r, out_len_nxt;

  logic                    clr_offs;
  logic                    upd_off;
  logic                    app_blk;

  logic [ALIGN_W-1:0]      lg;
  logic [AMASK_W-1:0]      amask;
  logic [IDX_W-1:0]        ent;
  logic [SIZE_BITS-1:0]    ent_len;
  logic [AL_W-1:0]         al;
  logic [SUM_W-1:0]        end_sum;
  logic                    hit;
  logic                    at_end;
  logic                    pool_full;
  logic [SIZE_BITS-1:0]    new_len;

  // Alignment mask, saturated at the largest supported alignment.
  assign lg    = (cfg.align_log2 > ALIGN_W'(ALIGN_MAX)) ? ALIGN_W'(ALIGN_MAX) : cfg.align_log2;
  assign amask = (AMASK_W'(1) << lg) - AMASK_W'(1);

  // Evaluate the block under the scan pointer.
  assign ent     = scan_idx_r[IDX_W-1:0];
  assign ent_len = len_r[ent];
  assign al      = (AL_W'(off_r[ent]) + AL_W'(amask)) & ~AL_W'(amask);
  assign end_sum = SUM_W'(al) + SUM_W'(cur_r.size);
  assign hit     = (end_sum <= SUM_W'(ent_len))
                   && (!cur_r.minimal || (ent_len == cur_r.size));
  assign at_end    = (scan_idx_r == count_r);
  assign pool_full = (count_r == CNT_W'(MAX_BLOCKS));

  // Length of an appended block.
  assign new_len = cur_r.minimal ? cur_r.size
                 : ((cfg.default_len > cur_r.size) ? cfg.default_len : cur_r.size);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && (q_item.cls == CL_ALLOC)) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (at_end || hit) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath control and result values.
  always_comb begin
    q_pop          = 1'b0;
    cur_nxt        = cur_r;
    scan_idx_nxt   = scan_idx_r;
    count_nxt      = count_r;
    clr_offs       = 1'b0;
    upd_off        = 1'b0;
    app_blk        = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_idx_nxt    = '0;
    out_off_nxt    = '0;
    out_nb_nxt     = 1'b0;
    out_len_nxt    = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          unique case (q_item.cls)
            CL_RESET: begin
              clr_offs      = 1'b1;
              out_valid_nxt = 1'b1;
            end
            CL_ZERO: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_ZERO;
            end
            CL_ALLOC: begin
              scan_idx_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (at_end) begin
          out_valid_nxt = 1'b1;
          if (pool_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            app_blk     = 1'b1;
            count_nxt   = count_r + 1'b1;
            out_idx_nxt = BLK_IDX_W'(count_r);
            out_nb_nxt  = 1'b1;
            out_len_nxt = new_len;
          end
        end else if (hit) begin
          upd_off       = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = BLK_IDX_W'(ent);
          out_off_nxt   = SIZE_BITS'(al);
          out_len_nxt   = ent_len;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    scan_idx_r   <= scan_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_off_r    <= out_off_nxt;
    out_nb_r     <= out_nb_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Block table: lengths and bump offsets.
  always_ff @(posedge clk) begin
    if (clr_offs) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        off_r[i] <= '0;
      end
    end else if (upd_off) begin
      off_r[ent] <= OFF_W'(end_sum);
    end else if (app_blk) begin
      off_r[count_r[IDX_W-1:0]] <= OFF_W'(cur_r.size);
    end
    if (app_blk) begin
      len_r[count_r[IDX_W-1:0]] <= new_len;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_index   = out_idx_r;
  assign out_grant_offset  = out_off_r;
  assign out_new_block     = out_nb_r;
  assign out_chosen_length = out_len_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("blocks in use above pool size");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN) |-> (scan_idx_r <= count_r))
    else $error("scan pointer past blocks in use");
  a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN && at_end && !pool_full)
      |=> (out_valid_r && out_nb_r && count_r == $past(count_r) + 1'b1))
    else $error("append without new-block result");
  a_newblk_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nb_r) |-> (out_status_r == ST_OK))
    else $error("new-block flag on a failed request");
`endif

endmodule

`default_nettype wire

// ----- design/aligned_bump_block_pool.sv -----
// Top level of the aligned bump block pool: configuration registers and the two parts.
//
//   Channel   Direction  Handshake             Payload
//   in_*      input      start high, busy low  in_command, in_request_size, in_minimal
//   out_*     output     out_valid, one cycle  out_status, out_block_index,
//                                              out_grant_offset, out_new_block,
//                                              out_chosen_length
//   cfg_*     input      cfg_we                cfg_index, cfg_wdata
//
// A reset or zero-size command is written into the queue, popped by the idle back part
// and answered from its output registers. An allocate is handled by the back part's
// first-fit scan over the blocks in use, one block per cycle in its compare unit.
// Up to two commands wait in the queue; busy is high while the queue is full.
// rst_n is synchronous; it empties the pool and loads the register reset values.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

module aligned_bump_block_pool
  import abbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_command,
  input  wire logic [SIZE_BITS-1:0]  in_request_size,
  input  wire logic                  in_minimal,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [BLK_IDX_W-1:0]       out_block_index,
  output logic [SIZE_BITS-1:0]       out_grant_offset,
  output logic                       out_new_block,
  output logic [SIZE_BITS-1:0]       out_chosen_length,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg_r, cfg_nxt;
  logic        q_valid;
  work_item_t  q_item;
  logic        q_pop;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_LEN: cfg_nxt.default_len = SIZE_BITS'(cfg_wdata);
        CFG_ALIGN_LOG2:  cfg_nxt.align_log2  = cfg_wdata[ALIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_len <= RESET_DEFAULT_LENGTH;
      cfg_r.align_log2  <= RESET_ALIGN_LOG2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Command intake and queue.
  abbp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_request_size (in_request_size),
    .in_minimal      (in_minimal),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Pool scan and result beats.
  abbp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_index   (out_block_index),
    .out_grant_offset  (out_grant_offset),
    .out_new_block     (out_new_block),
    .out_chosen_length (out_chosen_length)
  );

endmodule

`default_nettype wire
